FILE: hw/rtl/wrfft_pkg.sv
// shared types, constants and coefficient functions of the windowed fft frame core
package wrfft_pkg;

  localparam int DEF_POINTS      = 1024;
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int BIN_W           = 10;
  localparam int CFG_DATA_W      = 8;

  // request kinds carried on the input tuser
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef enum logic [1:0] {
    WIN_NONE     = 2'd0,
    WIN_HANN     = 2'd1,
    WIN_HAMMING  = 2'd2,
    WIN_BLACKMAN = 2'd3
  } win_kind_t;

  typedef enum logic [0:0] {
    REG_WINDOW_KIND  = 1'b0,
    REG_INVERSE_MODE = 1'b1
  } cfg_reg_t;

  // unsigned 64-bit quotient by restoring shift and subtract, elaboration only
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // cos(2 pi phase / 2^32) in q2.30 by integer taylor series, elaboration only
  function automatic longint cos_q30(input logic [31:0] phase);
    longint unsigned r;
    longint unsigned x;
    longint unsigned t;
    longint c;
    longint s;
    r = 64'(phase[29:0]);
    x = (r * 64'd1686629713) >> 30;
    t = 64'd1 << 30;
    c = longint'(t);
    s = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      t = udiv64((((t * x) >> 30) * x) >> 30, 64'((2 * k - 1) * (2 * k)));
      c = ((k & 1) != 0) ? c - longint'(t) : c + longint'(t);
    end
    t = x;
    for (int k = 1; k <= 6; k++) begin
      t = udiv64((((t * x) >> 30) * x) >> 30, 64'((2 * k) * (2 * k + 1)));
      s = ((k & 1) != 0) ? s - longint'(t) : s + longint'(t);
    end
    case (phase[31:30])
      2'd0:    return c;
      2'd1:    return -s;
      2'd2:    return -c;
      default: return s;
    endcase
  endfunction

  // q2.30 to q1.15, round half away from zero, saturate
  function automatic logic signed [15:0] q15_from_q30(input longint v);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + 64'sd16384) >>> 15;
    if (v < 0) begin
      return (mag > 64'sd32768) ? -16'sd32768 : 16'(-mag);
    end
    return (mag > 64'sd32767) ? 16'sd32767 : 16'(mag);
  endfunction

  // window value in q1.15 for one phase step
  function automatic logic signed [15:0] win_q15(input win_kind_t kind, input logic [31:0] ph);
    longint c0;
    longint c1;
    longint c2;
    longint w;
    longint q;
    case (kind)
      WIN_HAMMING: begin
        c0 = 538360; c1 = 461640; c2 = 0;
      end
      WIN_BLACKMAN: begin
        c0 = 426590; c1 = 496560; c2 = 76849;
      end
      default: begin
        c0 = 500000; c1 = 500000; c2 = 0;
      end
    endcase
    w = c0 * (64'sd1 <<< 30) - c1 * cos_q30(ph) + c2 * cos_q30({ph[30:0], 1'b0});
    if (w < 0) begin
      w = 0;
    end
    q = longint'(udiv64(64'(w + 64'sd1000000 * (64'sd1 <<< 14)),
                        64'(64'sd1000000 * (64'sd1 <<< 15))));
    return (q > 64'sd32767) ? 16'sd32767 : 16'(q);
  endfunction

endpackage

FILE: hw/rtl/wrfft_ram.sv
// generic single write port, single read port ram with registered read
module wrfft_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/wrfft_coef_rom.sv
// twiddle and window coefficient roms, q1.15, registered read
module wrfft_coef_rom #(
  parameter int POINTS = wrfft_pkg::DEF_POINTS,
  localparam int LG    = $clog2(POINTS)
) (
  input  logic                        clk,
  input  logic [LG-2:0]               tw_addr,
  input  wrfft_pkg::win_kind_t        win_kind,
  input  logic [LG-1:0]               win_addr,
  output logic signed [15:0]          tw_re,
  output logic signed [15:0]          tw_im,
  output logic signed [15:0]          win_coef
);
  import wrfft_pkg::*;

  localparam int HALF = POINTS / 2;

  logic signed [15:0] tw_re_tab   [HALF];
  logic signed [15:0] tw_im_tab   [HALF];
  logic signed [15:0] hann_tab    [POINTS];
  logic signed [15:0] hamming_tab [POINTS];
  logic signed [15:0] black_tab   [POINTS];

  // twiddles exp(-j 2 pi i / points)
  for (genvar i = 0; i < HALF; i++) begin : g_tw
    localparam logic [31:0] PH = 32'(64'(i) << (32 - LG));
    localparam logic signed [15:0] TRE = q15_from_q30(cos_q30(PH));
    localparam logic signed [15:0] TIM = q15_from_q30(cos_q30(PH + 32'h4000_0000));
    assign tw_re_tab[i] = TRE;
    assign tw_im_tab[i] = TIM;
  end

  // window tables over angle 2 pi i / (points - 1)
  for (genvar i = 0; i < POINTS; i++) begin : g_win
    localparam logic [31:0] WPH = 32'((64'(i) << 32) / (POINTS - 1));
    localparam logic signed [15:0] WHN = win_q15(WIN_HANN, WPH);
    localparam logic signed [15:0] WHM = win_q15(WIN_HAMMING, WPH);
    localparam logic signed [15:0] WBK = win_q15(WIN_BLACKMAN, WPH);
    assign hann_tab[i]    = WHN;
    assign hamming_tab[i] = WHM;
    assign black_tab[i]   = WBK;
  end

  // registered lookups
  always_ff @(posedge clk) begin
    tw_re <= tw_re_tab[tw_addr];
    tw_im <= tw_im_tab[tw_addr];
    case (win_kind)
      WIN_HANN:     win_coef <= hann_tab[win_addr];
      WIN_HAMMING:  win_coef <= hamming_tab[win_addr];
      WIN_BLACKMAN: win_coef <= black_tab[win_addr];
      default:      win_coef <= 16'sd32767;
    endcase
  end

endmodule

FILE: hw/rtl/windowed_radix2_fft_frame_core.sv
// top level: frame loading, in-place dif fft sequencer and bin readout
//
//  channel | dir | handshake             | payload
//  in_     | in  | in_tvalid/in_tready   | tuser req_type, tdata sample_re/sample_im/bin_index
//  out_    | out | out_tvalid/out_tready | tuser not_ready, tdata bin_re/bin_im/bin_number
//  cfg_    | in  | cfg_valid/cfg_ready   | cfg_index register, cfg_data value
//
// a push is written on acceptance; a read answer passes the ram and output registers
// the last push of a frame starts the transform, all through the one sample ram:
//   optional window or conjugate pass, butterflies, inverse scaling pass;
//   no input is taken meanwhile
// reset clears the load count, frame status, cfg registers and out valid; ram is left as is
// a stalled output holds its transaction, a new input waits until the output slot frees
module windowed_radix2_fft_frame_core #(
  parameter int POINTS      = wrfft_pkg::DEF_POINTS,
  parameter int SAMPLE_BITS = wrfft_pkg::DEF_SAMPLE_BITS,
  localparam int LG         = $clog2(POINTS),
  localparam int ACC        = SAMPLE_BITS + LG + 1,
  localparam int IN_W       = ((2 * SAMPLE_BITS + wrfft_pkg::BIN_W + 7) / 8) * 8,
  localparam int OUT_W      = ((2 * ACC + wrfft_pkg::BIN_W + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [IN_W-1:0]                   in_tdata,   // sample_re, sample_im, bin_index
  input  logic                              in_tuser,   // req_type
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [OUT_W-1:0]                  out_tdata,  // bin_re, bin_im, bin_number
  output logic                              out_tuser,  // not_ready
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  wrfft_pkg::cfg_reg_t               cfg_index,
  input  logic [wrfft_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import wrfft_pkg::*;

  localparam int SW   = $clog2(LG);
  localparam int PW   = ACC + 17;
  localparam int SATW = ACC + 18;
  localparam int DW   = 2 * ACC;
  localparam logic signed [SATW-1:0] RND15  = SATW'(16384);
  localparam logic signed [SATW-1:0] RND_LG = SATW'(POINTS / 2);

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_WAIT, ST_PASS_RD, ST_PASS_CALC, ST_PASS_WR,
    ST_BF_RDA, ST_BF_RDB, ST_BF_SUM, ST_BF_MUL1, ST_BF_MUL2, ST_BF_WRB
  } state_t;

  state_t                  state_r;
  logic                    frame_done_r;
  logic [LG-1:0]           load_cnt_r;
  win_kind_t               kind_r, run_kind_r;
  logic                    inv_r, run_inv_r, post_r;
  logic [LG-1:0]           idx_r;
  logic [LG-2:0]           bf_j_r;
  logic [SW-1:0]           stage_r;
  logic signed [ACC-1:0]   a_re_r, a_im_r, x_re_r, x_im_r, sum_re_r, sum_im_r;
  logic signed [ACC:0]     dr_r, di_r;
  logic signed [PW-1:0]    p0_r, p1_r, p2_r, p3_r;
  logic                    out_tvalid_r, out_nr_r;
  logic signed [ACC-1:0]   out_re_r, out_im_r;
  logic [BIN_W-1:0]        bin_num_r;

  logic                    in_acc, last_push;
  logic [LG-1:0]           wr_idx, rd_idx, rev_idx;
  logic [LG-1:0]           bf_a, bf_b, low_mask, jx;
  logic [SW-1:0]           m_sh;
  logic [LG-2:0]           tw_addr;
  logic                    ram_we;
  logic [LG-1:0]           ram_waddr, ram_raddr;
  logic [DW-1:0]           ram_wdata, ram_rdata;
  logic signed [ACC-1:0]   rd_re, rd_im;
  logic signed [15:0]      tw_re, tw_im, win_coef;
  logic [BIN_W-1:0]        in_bin;

  function automatic logic signed [ACC-1:0] sat_acc(input logic signed [SATW-1:0] v);
    if (v[SATW-1:ACC-1] == '0 || v[SATW-1:ACC-1] == '1) begin
      return v[ACC-1:0];
    end
    return v[SATW-1] ? {1'b1, {(ACC-1){1'b0}}} : {1'b0, {(ACC-1){1'b1}}};
  endfunction

  wrfft_ram #(.W(DW), .DEPTH(POINTS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  wrfft_coef_rom #(.POINTS(POINTS)) u_rom (
    .clk      (clk),
    .tw_addr  (tw_addr),
    .win_kind (run_kind_r),
    .win_addr (idx_r),
    .tw_re    (tw_re),
    .tw_im    (tw_im),
    .win_coef (win_coef)
  );

  // handshakes and field decode
  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE) && (!out_tvalid_r || out_tready);
  assign in_acc     = in_tvalid && in_tready;
  assign in_bin     = in_tdata[2*SAMPLE_BITS +: BIN_W];
  assign wr_idx     = frame_done_r ? '0 : load_cnt_r;
  assign last_push  = (wr_idx == '1);
  assign rd_idx     = LG'(in_bin);
  assign rd_re      = $signed(ram_rdata[ACC-1:0]);
  assign rd_im      = $signed(ram_rdata[DW-1:ACC]);

  // bit reversal of the read address
  always_comb begin
    for (int q = 0; q < LG; q++) begin
      rev_idx[q] = rd_idx[LG-1-q];
    end
  end

  // butterfly addressing: insert a zero bit at position m into j
  always_comb begin
    m_sh     = SW'(LG - 1) - stage_r;
    jx       = {1'b0, bf_j_r};
    low_mask = (LG'(1) << m_sh) - LG'(1);
    bf_a     = ((jx >> m_sh) << (m_sh + SW'(1))) | (jx & low_mask);
    bf_b     = bf_a | (LG'(1) << m_sh);
    tw_addr  = (bf_j_r & low_mask[LG-2:0]) << stage_r;
  end

  // ram port control and write data
  always_comb begin
    logic signed [SATW-1:0] t0, t1;
    logic signed [ACC-1:0]  w_re, w_im;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_raddr = idx_r;
    t0        = '0;
    t1        = '0;
    w_re      = '0;
    w_im      = '0;
    case (state_r)
      ST_IDLE: begin
        ram_waddr = wr_idx;
        ram_raddr = rev_idx;
        ram_we    = in_acc && (in_tuser == REQ_PUSH);
        w_re      = ACC'($signed(in_tdata[SAMPLE_BITS-1:0]));
        w_im      = ACC'($signed(in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));
      end
      ST_PASS_WR: begin
        ram_we = 1'b1;
        if (post_r) begin
          t0   = SATW'(x_re_r) + RND_LG;
          t1   = -SATW'(x_im_r) + RND_LG;
          t0   = t0 >>> LG;
          t1   = t1 >>> LG;
          w_re = sat_acc(t0);
          w_im = sat_acc(t1);
        end else if (run_inv_r) begin
          w_re = x_re_r;
          w_im = -x_im_r;
        end else begin
          t0   = SATW'(p0_r) + RND15;
          t1   = SATW'(p1_r) + RND15;
          t0   = t0 >>> 15;
          t1   = t1 >>> 15;
          w_re = t0[ACC-1:0];
          w_im = t1[ACC-1:0];
        end
      end
      ST_BF_RDA: ram_raddr = bf_a;
      ST_BF_RDB: ram_raddr = bf_b;
      ST_BF_MUL1: begin
        ram_we    = 1'b1;
        ram_waddr = bf_a;
        w_re      = sum_re_r;
        w_im      = sum_im_r;
      end
      ST_BF_WRB: begin
        ram_we    = 1'b1;
        ram_waddr = bf_b;
        t0        = SATW'(p0_r) - SATW'(p1_r) + RND15;
        t1        = SATW'(p2_r) + SATW'(p3_r) + RND15;
        t0        = t0 >>> 15;
        t1        = t1 >>> 15;
        w_re      = sat_acc(t0);
        w_im      = sat_acc(t1);
      end
      default: ;
    endcase
    ram_wdata = {w_im, w_re};
  end

  // sequencer, configuration registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      frame_done_r <= 1'b0;
      load_cnt_r   <= '0;
      kind_r       <= WIN_NONE;
      inv_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_WINDOW_KIND:  kind_r <= win_kind_t'(cfg_data[1:0]);
          REG_INVERSE_MODE: inv_r  <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_tuser == REQ_PUSH) begin
              frame_done_r <= 1'b0;
              if (last_push) begin
                load_cnt_r <= '0;
                run_kind_r <= kind_r;
                run_inv_r  <= inv_r;
                idx_r      <= '0;
                bf_j_r     <= '0;
                stage_r    <= '0;
                post_r     <= 1'b0;
                state_r    <= (inv_r || kind_r != WIN_NONE) ? ST_PASS_RD : ST_BF_RDA;
              end else begin
                load_cnt_r <= wr_idx + LG'(1);
              end
            end else begin
              bin_num_r <= in_bin;
              state_r   <= ST_RD_WAIT;
            end
          end
        end
        ST_RD_WAIT: begin
          out_tvalid_r <= 1'b1;
          out_nr_r     <= !frame_done_r;
          out_re_r     <= frame_done_r ? rd_re : '0;
          out_im_r     <= frame_done_r ? rd_im : '0;
          state_r      <= ST_IDLE;
        end
        ST_PASS_RD: state_r <= ST_PASS_CALC;
        ST_PASS_CALC: begin
          x_re_r  <= rd_re;
          x_im_r  <= rd_im;
          p0_r    <= rd_re * win_coef;
          p1_r    <= rd_im * win_coef;
          state_r <= ST_PASS_WR;
        end
        ST_PASS_WR: begin
          idx_r <= idx_r + LG'(1);
          if (idx_r == '1) begin
            if (post_r) begin
              frame_done_r <= 1'b1;
              state_r      <= ST_IDLE;
            end else begin
              state_r <= ST_BF_RDA;
            end
          end else begin
            state_r <= ST_PASS_RD;
          end
        end
        ST_BF_RDA: state_r <= ST_BF_RDB;
        ST_BF_RDB: begin
          a_re_r  <= rd_re;
          a_im_r  <= rd_im;
          state_r <= ST_BF_SUM;
        end
        ST_BF_SUM: begin
          sum_re_r <= sat_acc(SATW'(a_re_r) + SATW'(rd_re));
          sum_im_r <= sat_acc(SATW'(a_im_r) + SATW'(rd_im));
          dr_r     <= (ACC+1)'(a_re_r) - (ACC+1)'(rd_re);
          di_r     <= (ACC+1)'(a_im_r) - (ACC+1)'(rd_im);
          state_r  <= ST_BF_MUL1;
        end
        ST_BF_MUL1: begin
          p0_r    <= dr_r * tw_re;
          p1_r    <= di_r * tw_im;
          state_r <= ST_BF_MUL2;
        end
        ST_BF_MUL2: begin
          p2_r    <= dr_r * tw_im;
          p3_r    <= di_r * tw_re;
          state_r <= ST_BF_WRB;
        end
        ST_BF_WRB: begin
          bf_j_r <= bf_j_r + (LG-1)'(1);
          if (bf_j_r == '1) begin
            stage_r <= stage_r + SW'(1);
            if (stage_r == SW'(LG - 1)) begin
              if (run_inv_r) begin
                post_r  <= 1'b1;
                idx_r   <= '0;
                state_r <= ST_PASS_RD;
              end else begin
                frame_done_r <= 1'b1;
                state_r      <= ST_IDLE;
              end
            end else begin
              state_r <= ST_BF_RDA;
            end
          end else begin
            state_r <= ST_BF_RDA;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // result channel
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_nr_r;
  assign out_tdata  = OUT_W'({bin_num_r, out_im_r, out_re_r});

endmodule

FILE: hw/rtl/wrfft_checker.sv
// port-level assertions for the fft frame core, attached by bind
module wrfft_checker #(
  parameter int ACC   = 27,
  parameter int OUT_W = 64
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             in_tuser,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tuser
);
  import wrfft_pkg::*;

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // every accepted read is answered with a valid result
  a_read_answer: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == REQ_READ |=> ##1 out_tvalid)
    else $error("read not answered");

  // a push causes no result
  a_push_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == REQ_PUSH && !out_tvalid |=> !out_tvalid ##1 !out_tvalid)
    else $error("push produced a result");

  // reads before a finished frame return zero bins
  a_not_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[2*ACC-1:0] == '0)
    else $error("not-ready result carries data");

endmodule

bind windowed_radix2_fft_frame_core wrfft_checker #(.ACC(ACC), .OUT_W(OUT_W)) u_wrfft_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
